// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;
   localparam int NumParts  = 4;
   localparam int MaxBlocks = 16;
   localparam int PartW  = 2;
   localparam int BlkW   = 4;
   localparam int AddrW  = PartW + BlkW;
   localparam int CntW   = 5;
   localparam int SizeW  = 16;
   localparam int OffW   = 32;
   localparam int NumRegs = 8;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 16;
   localparam logic [SizeW-1:0] ResetSize0  = 16'd1024;
   localparam logic [CntW-1:0]  ResetCount0 = 5'd16;

   localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREED      = 2'd2;
   localparam logic [1:0] ST_FREE_IGN   = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;
endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_type, req_size, req_free_offset
// rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_block_offset, rsp_part_index
// csr     | in        | csr_we               | csr_index, csr_data
// one word at a time: 4 base steps, 1 to 5 partition select steps, then for an allocate
// a block scan and a rank update, for a free a 32-step restoring divide, a lookup in
// S_FREE and S_FGET and a rank update; S_FIN writes back for a served word, and S_RSP
// raises rsp_valid. reset or any csr write starts a pass that rebuilds the free list,
// during which the block is not ready. the result sits in an output register;
// req_ready stays low until it is taken.
module fixed_block_pool_allocator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_type,
   input  logic [15:0] req_size,
   input  logic [31:0] req_free_offset,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_block_offset,
   output logic [1:0] rsp_part_index,
   input  logic csr_we,
   input  logic [fbpa_pkg::CsrIdxW-1:0] csr_index,
   input  logic [fbpa_pkg::CsrDataW-1:0] csr_data
);
   import fbpa_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_BASE = 4'd1, S_PSEL = 4'd2, S_SCAN = 4'd3,
      S_REL = 4'd4, S_DIV = 4'd5, S_FREE = 4'd6, S_RSP = 4'd7, S_INIT = 4'd8,
      S_FGET = 4'd9, S_FIN = 4'd10;

   logic [3:0] state_ff;
   logic [SizeW-1:0] size_ff [NumParts];
   logic [CntW-1:0]  cnt_ff  [NumParts];
   logic [CntW-1:0]  tot_ff  [NumParts];
   logic [OffW+1:0]  acc_ff;          // running base, kept 34 bits wide
   logic [OffW+1:0]  basew_ff [NumParts];
   logic [PartW:0]   p_ff;
   logic [BlkW:0]    i_ff;
   logic [BlkW-1:0]  rdi_ff;          // block whose list entry is on the read port
   logic             rdv_ff;
   logic [AddrW-1:0] ini_ff;
   logic             typ_ff;
   logic [SizeW-1:0] want_ff;
   logic [OffW-1:0]  off_ff;
   logic [OffW-1:0]  quo_ff;
   logic [SizeW:0]   rem_ff;
   logic [5:0]       dc_ff;
   logic [BlkW-1:0]  hit_ff;
   logic [BlkW-1:0]  rr_ff;          // rank being unlinked
   logic             unl_ff;
   logic [1:0]       st_ff;
   logic [OffW-1:0]  bo_ff;
   logic [PartW-1:0] pi_ff;
   logic             rv_ff;

   // effective count of a partition
   function automatic logic [CntW-1:0] eff(input logic [SizeW-1:0] s,
                                           input logic [CntW-1:0] c);
      if (s == '0) return '0;
      if (c > CntW'(MaxBlocks)) return CntW'(MaxBlocks);
      return c;
   endfunction

   logic [PartW-1:0] p2;
   logic [BlkW-1:0]  i2;
   logic [CntW-1:0]  effp;
   logic [SizeW+CntW-1:0] span;
   logic [OffW+1:0] endw;
   logic [SizeW:0]  remsh;
   logic [SizeW+BlkW-1:0] blk_off;
   logic [PartW-1:0] ini_p;
   logic [BlkW-1:0]  ini_i;
   logic [CntW-1:0]  ini_n;
   logic             ini_free;
   logic             mem_we;
   logic [AddrW-1:0] mem_waddr;
   logic [AddrW-1:0] mem_raddr;
   logic [BlkW:0]    mem_wdata;
   logic [BlkW:0]    mem_rdata;
   logic             rd_free;
   logic [BlkW-1:0]  rd_rank;
   logic             rd_issue;
   logic             scan_hit;
   logic             rel_dec;
   logic [BlkW-1:0]  fin_rank;

   assign p2   = p_ff[PartW-1:0];
   assign i2   = i_ff[BlkW-1:0];
   assign effp = eff(size_ff[p2], cnt_ff[p2]);
   assign span = size_ff[p2] * effp;
   assign endw = basew_ff[p2] + (OffW+2)'(span);
   assign remsh = {rem_ff[SizeW-1:0], quo_ff[OffW-1]};
   assign blk_off = rdi_ff * size_ff[p2];

   // free list entry: {free flag, rank in the free order}
   assign rd_free = mem_rdata[BlkW];
   assign rd_rank = mem_rdata[BlkW-1:0];
   assign ini_p = ini_ff[AddrW-1:BlkW];
   assign ini_i = ini_ff[BlkW-1:0];
   assign ini_n = eff(size_ff[ini_p], cnt_ff[ini_p]);
   assign ini_free = ({1'b0, ini_i} < ini_n);

   // reads are pipelined: the entry asked for in one cycle is checked in the next
   assign scan_hit = rdv_ff && rd_free && (rd_rank == '0);
   assign rel_dec  = rdv_ff && unl_ff && (rdi_ff != hit_ff) && rd_free && (rd_rank > rr_ff);
   assign rd_issue = !i_ff[BlkW] && ((state_ff == S_SCAN && !scan_hit) || state_ff == S_REL);
   assign fin_rank = unl_ff ? BlkW'(tot_ff[p2] - 1'b1) : BlkW'(tot_ff[p2]);

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_block_offset = bo_ff;
   assign rsp_part_index = pi_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {p2, rdi_ff};
      mem_wdata = {1'b1, rd_rank - 1'b1};
      mem_raddr = {p2, i2};
      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = ini_ff;
            mem_wdata = {ini_free, ini_i & {BlkW{ini_free}}};
         end
         S_REL: mem_we = rel_dec;
         S_FREE: mem_raddr = {p2, quo_ff[BlkW-1:0]};
         S_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = {p2, hit_ff};
            mem_wdata = (st_ff == ST_ALLOC_OK) ? '0 : {1'b1, fin_rank};
         end
         default: ;
      endcase
   end

   fbpa_ram #(.Width(BlkW + 1), .Depth(NumParts * MaxBlocks)) u_list (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NumParts; p++) begin
            size_ff[p] <= (p == 0) ? ResetSize0 : '0;
            cnt_ff[p]  <= (p == 0) ? ResetCount0 : '0;
         end
         ini_ff <= '0;
         state_ff <= S_INIT;
         rv_ff <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= rd_issue;
         rdi_ff <= i2;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (csr_we) begin
            if (int'(csr_index) < NumRegs) begin
               if (csr_index[0]) cnt_ff[csr_index[CsrIdxW-1:1]] <= csr_data[CntW-1:0];
               else size_ff[csr_index[CsrIdxW-1:1]] <= csr_data;
               ini_ff <= '0;
               state_ff <= S_INIT;
            end
         end else begin
            unique case (state_ff)
               S_INIT: begin
                  // one list entry a cycle; a partition's free total on its first entry
                  if (ini_i == '0) tot_ff[ini_p] <= ini_n;
                  ini_ff <= ini_ff + 1'b1;
                  if (ini_ff == '1) state_ff <= S_IDLE;
               end
               S_IDLE: if (req_valid && req_ready) begin
                  typ_ff <= req_type; want_ff <= req_size; off_ff <= req_free_offset;
                  p_ff <= '0; acc_ff <= '0; state_ff <= S_BASE;
               end
               S_BASE: begin
                  // one partition base per cycle through one multiplier
                  basew_ff[p2] <= acc_ff;
                  acc_ff <= acc_ff + (OffW+2)'(span);
                  if (p_ff == (PartW+1)'(NumParts-1)) begin
                     p_ff <= '0; state_ff <= S_PSEL;
                  end else p_ff <= p_ff + 1'b1;
               end
               S_PSEL: begin
                  if (p_ff == (PartW+1)'(NumParts)) begin
                     st_ff <= (typ_ff == REQ_ALLOC) ? ST_ALLOC_FAIL : ST_FREE_IGN;
                     bo_ff <= '0; pi_ff <= '0; state_ff <= S_RSP;
                  end else if (typ_ff == REQ_ALLOC) begin
                     if (effp == '0 || size_ff[p2] < want_ff || tot_ff[p2] == '0)
                        p_ff <= p_ff + 1'b1;
                     else begin
                        i_ff <= '0; state_ff <= S_SCAN;
                     end
                  end else begin
                     if (effp == '0 || {2'b0, off_ff} < basew_ff[p2] ||
                         {2'b0, off_ff} >= endw)
                        p_ff <= p_ff + 1'b1;
                     else begin
                        quo_ff <= off_ff - basew_ff[p2][OffW-1:0];
                        rem_ff <= '0; dc_ff <= '0; state_ff <= S_DIV;
                     end
                  end
               end
               S_SCAN: begin
                  // find rank-0 free block
                  if (scan_hit) begin
                     hit_ff <= rdi_ff; rr_ff <= '0;
                     bo_ff <= basew_ff[p2][OffW-1:0] + OffW'(blk_off);
                     st_ff <= ST_ALLOC_OK; pi_ff <= p2; unl_ff <= 1'b1;
                     i_ff <= '0; state_ff <= S_REL;
                  end else if (i_ff[BlkW]) begin
                     st_ff <= ST_ALLOC_FAIL; bo_ff <= '0; pi_ff <= '0; state_ff <= S_RSP;
                  end else i_ff <= i_ff + 1'b1;
               end
               S_DIV: begin
                  // restoring divide, one quotient bit per cycle
                  if (remsh >= {1'b0, size_ff[p2]}) begin
                     rem_ff <= remsh - {1'b0, size_ff[p2]};
                     quo_ff <= {quo_ff[OffW-2:0], 1'b1};
                  end else begin
                     rem_ff <= remsh;
                     quo_ff <= {quo_ff[OffW-2:0], 1'b0};
                  end
                  if (dc_ff == 6'd31) state_ff <= S_FREE;
                  dc_ff <= dc_ff + 1'b1;
               end
               S_FREE: begin
                  if (rem_ff != '0) begin
                     st_ff <= ST_FREE_IGN; bo_ff <= '0; pi_ff <= '0; state_ff <= S_RSP;
                  end else begin
                     hit_ff <= quo_ff[BlkW-1:0];
                     state_ff <= S_FGET;
                  end
               end
               S_FGET: begin
                  // list entry of the block being given back
                  rr_ff <= rd_rank;
                  unl_ff <= rd_free;
                  st_ff <= ST_FREED; bo_ff <= '0; pi_ff <= p2;
                  i_ff <= '0; state_ff <= S_REL;
               end
               S_REL: begin
                  // one block a cycle: close the gap left by the unlinked rank
                  if (i_ff[BlkW]) state_ff <= S_FIN;
                  else i_ff <= i_ff + 1'b1;
               end
               S_FIN: begin
                  if (st_ff == ST_ALLOC_OK) tot_ff[p2] <= tot_ff[p2] - 1'b1;
                  else if (!unl_ff) tot_ff[p2] <= tot_ff[p2] + 1'b1;
                  state_ff <= S_RSP;
               end
               S_RSP: begin
                  rv_ff <= 1'b1; state_ff <= S_IDLE;
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

`ifndef ASSERT_OFF
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP && !csr_we) |=> rsp_valid) else $error("no result");
   a_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_ALLOC_OK) |-> rsp_block_offset == '0)
      else $error("stray offset");
`endif
endmodule

module fbpa_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   assign rd_data = rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import fbpa_pkg::*;

   // register map: size and count of each partition, in pairs
   localparam logic [CsrIdxW-1:0] REG_P0_SIZE  = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_P0_COUNT = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_P1_SIZE  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_P1_COUNT = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_P2_SIZE  = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_P2_COUNT = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_P3_SIZE  = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_P3_COUNT = 3'd7;
   localparam logic [CsrIdxW-1:0] SIZE_REG  [NumParts] =
      '{REG_P0_SIZE, REG_P1_SIZE, REG_P2_SIZE, REG_P3_SIZE};
   localparam logic [CsrIdxW-1:0] COUNT_REG [NumParts] =
      '{REG_P0_COUNT, REG_P1_COUNT, REG_P2_COUNT, REG_P3_COUNT};

   // margin after the last result before a register write
   localparam int SettleCycles = 80;
   localparam int CycleLimit   = 600000;
   localparam int HoldOffCycles = 400;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_type;
   logic [15:0] req_size;
   logic [31:0] req_free_offset;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_status;
   logic [31:0] rsp_block_offset;
   logic [1:0] rsp_part_index;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_data;

   typedef struct packed {
      logic [1:0]  st;
      logic [31:0] off;
      logic [1:0]  part;
   } pool_result_type;

   // shadow copy of the pool
   logic [SizeW-1:0] part_size  [NumParts];
   logic [CntW-1:0]  part_count [NumParts];
   logic             blk_free   [NumParts][MaxBlocks];
   int unsigned      blk_rank   [NumParts][MaxBlocks];
   int unsigned      part_free_total [NumParts];

   pool_result_type pending_results[$];
   logic [31:0]  held_offsets[$];    // blocks handed out and not yet given back

   int  error_count;
   int  words_sent;
   int  results_seen;
   int  allocs_ok;
   int  allocs_failed;
   int  frees_ok;
   int  frees_ignored;
   int  cycle_count;
   int  stall_left;
   bit  quiet_tail;
   bit  hold_rsp;

   fixed_block_pool_allocator DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_size(req_size),
      .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_block_offset(rsp_block_offset),
      .rsp_part_index(rsp_part_index),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // pool predictor
   // ---------------------------------------------------------------

   // blocks actually in use: zero size means absent, count saturates at MaxBlocks
   function automatic int unsigned live_count(int p);
      if (part_size[p] == '0) return 0;
      if (part_count[p] > MaxBlocks) return MaxBlocks;
      return part_count[p];
   endfunction

   // arena start of partition p, partitions packed one after another
   function automatic longint unsigned arena_base(int p);
      longint unsigned b;
      b = 0;
      for (int q = 0; q < p; q++) b += longint'(live_count(q)) * part_size[q];
      return b;
   endfunction

   // every live block free, ranked by index
   function automatic void pool_rebuild();
      for (int p = 0; p < NumParts; p++) begin
         for (int i = 0; i < MaxBlocks; i++) begin
            blk_free[p][i] = (i < live_count(p));
            blk_rank[p][i] = (i < live_count(p)) ? i : 0;
         end
         part_free_total[p] = live_count(p);
      end
   endfunction

   // take block k out of the free order, closing the gap behind it
   function automatic void pool_unlink(int p, int k);
      int unsigned r;
      r = blk_rank[p][k];
      for (int j = 0; j < MaxBlocks; j++)
         if (j != k && blk_free[p][j] && blk_rank[p][j] > r) blk_rank[p][j]--;
      blk_free[p][k] = 1'b0;
      blk_rank[p][k] = 0;
      if (part_free_total[p] > 0) part_free_total[p]--;
   endfunction

   function automatic pool_result_type pool_serve(logic kind, logic [15:0] want,
                                                  logic [31:0] off);
      pool_result_type r;
      longint unsigned base, d, span;
      bit done;
      int n;
      int idx;
      r = '{st: ST_ALLOC_FAIL, off: '0, part: '0};
      done = 0;
      if (kind == REQ_ALLOC) begin
         for (int p = 0; p < NumParts && !done; p++) begin
            if (live_count(p) == 0 || part_size[p] < want || part_free_total[p] == 0)
               continue;
            for (int i = 0; i < MaxBlocks && !done; i++) begin
               if (blk_free[p][i] && blk_rank[p][i] == 0) begin
                  base = arena_base(p) + longint'(i) * part_size[p];
                  r = '{st: ST_ALLOC_OK, off: base[31:0], part: p[1:0]};
                  pool_unlink(p, i);
                  done = 1;
               end
            end
         end
      end else begin
         r.st = ST_FREE_IGN;
         for (int p = 0; p < NumParts && !done; p++) begin
            n = live_count(p);
            if (n == 0) continue;
            base = arena_base(p);
            span = longint'(n) * part_size[p];
            if (off < base || off >= base + span) continue;
            done = 1;
            d = off - base;
            // only an exact block start is taken back; a free block moves to the tail
            if (d % part_size[p] == 0) begin
               idx = int'(d / part_size[p]);
               if (blk_free[p][idx]) pool_unlink(p, idx);
               blk_free[p][idx] = 1'b1;
               blk_rank[p][idx] = part_free_total[p];
               part_free_total[p]++;
               r = '{st: ST_FREED, off: '0, part: p[1:0]};
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------

   task automatic send_word(logic kind, logic [15:0] want, logic [31:0] off);
      pool_result_type exp;
      // random idle burst before the word, never in the quiet tail
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_size        <= want;
      req_free_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge: predict now
      exp = pool_serve(kind, want, off);
      pending_results.push_back(exp);
      if (exp.st == ST_ALLOC_OK) held_offsets.push_back(exp.off);
      words_sent++;
   endtask

   task automatic alloc_word(logic [15:0] want);
      send_word(REQ_ALLOC, want, $urandom);
   endtask

   task automatic free_word(logic [31:0] off);
      send_word(REQ_FREE, 16'($urandom), off);
   endtask

   // let everything drain so that a register write finds the block idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      // mirror the write: any write re-initializes the pool
      if (idx[0] == 1'b0) part_size[idx >> 1] = data;
      else part_count[idx >> 1] = data[CntW-1:0];
      pool_rebuild();
      held_offsets.delete();
   endtask

   task automatic set_partition(int p, logic [15:0] sz, logic [4:0] cnt);
      csr_write(SIZE_REG[p], sz);
      // upper data bits are don't-care for the count, so scramble them
      csr_write(COUNT_REG[p], {11'($urandom_range(0, 2047)), cnt});
   endtask

   // ---------------------------------------------------------------
   // checking and receiver stalls
   // ---------------------------------------------------------------

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      pool_result_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report("unexpected word, status", 32'(rsp_status), 32'd0);
            end else begin
               exp = pending_results.pop_front();
               if (rsp_status !== exp.st)
                  report("status", 32'(rsp_status), 32'(exp.st));
               if (rsp_block_offset !== exp.off)
                  report("block_offset", rsp_block_offset, exp.off);
               if (rsp_part_index !== exp.part)
                  report("part_index", 32'(rsp_part_index), 32'(exp.part));
               case (exp.st)
                  ST_ALLOC_OK:   allocs_ok++;
                  ST_ALLOC_FAIL: allocs_failed++;
                  ST_FREED:      frees_ok++;
                  default:       frees_ignored++;
               endcase
            end
         end
         // long hold-off wins, then short random stall bursts
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset layout: one partition of 16 x 1024 bytes
   task automatic test_reset_layout();
      alloc_word(16'd0);            // zero size fits
      alloc_word(16'd1024);         // exact fit
      alloc_word(16'd1025);         // too large
      alloc_word(16'hFFFF);
      free_word(32'd0);             // give back block 0
      free_word(32'd0);             // already free, moves to tail
      free_word(32'd512);           // not a block start
      free_word(32'd16384);         // just past the arena
      free_word(32'hFFFF_FFFF);
      free_word(32'd1024);
      for (int i = 0; i < 17; i++) alloc_word(16'd1);   // drain and overflow
   endtask

   // absent partitions, saturated count, first-fit across partitions
   task automatic test_partitions();
      set_partition(0, 16'd64, 5'd2);
      set_partition(1, 16'd0, 5'd5);       // zero size: absent
      set_partition(2, 16'hFFFF, 5'd31);   // count saturates
      set_partition(3, 16'd100, 5'd0);     // zero count: absent
      alloc_word(16'd64);
      alloc_word(16'd10);
      alloc_word(16'd10);                  // spills to partition two
      alloc_word(16'hFFFF);
      free_word(32'd128);                  // first block of partition two
      free_word(32'd128 + 32'd65535 * 15); // last block
      free_word(32'd128 + 32'd65535 * 16); // past the end
      free_word(32'd64);
      alloc_word(16'd1);
      set_partition(3, 16'd100, 5'd16);
      alloc_word(16'd100);
      set_partition(0, 16'd1, 5'd16);
      alloc_word(16'd0);
      free_word(32'd15);
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_backpressure();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) alloc_word(16'($urandom_range(0, 2)));
   endtask

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom);
         default: return 16'($urandom_range(1, 300));
      endcase
   endfunction

   task automatic random_config();
      for (int p = 0; p < NumParts; p++)
         set_partition(p, ($urandom_range(0, 5) == 0) ? 16'd0 : pick_size(),
                       5'($urandom_range(0, 31)));
   endtask

   // mostly alloc/free of live blocks, with noise mixed in
   task automatic random_word();
      int sel;
      int k;
      int p;
      logic [31:0] off;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         p = $urandom_range(0, NumParts - 1);
         alloc_word(($urandom_range(0, 3) == 0) ? pick_size()
                    : 16'(part_size[p] - 16'($urandom_range(0, 1))));
      end else if (sel < 80 && held_offsets.size() != 0) begin
         k = $urandom_range(0, held_offsets.size() - 1);
         off = held_offsets[k];
         held_offsets.delete(k);
         free_word(off);
      end else if (sel < 90) begin
         // a block start, free or not, or a near miss
         p = $urandom_range(0, NumParts - 1);
         off = 32'(arena_base(p) + part_size[p] * $urandom_range(0, 17));
         free_word(off + 32'($urandom_range(0, 1)));
      end else begin
         free_word($urandom);
      end
   endtask

   task automatic test_random(int phases, int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         random_config();
         for (int i = 0; i < per_phase; i++) random_word();
      end
   endtask

   // last stretch with no idling on either side
   task automatic test_full_rate();
      quiet_tail = 1'b1;
      set_partition(0, 16'd8, 5'd16);
      for (int i = 0; i < 120; i++) random_word();
   endtask

   initial begin
      error_count = 0;
      words_sent = 0;
      results_seen = 0;
      allocs_ok = 0;
      allocs_failed = 0;
      frees_ok = 0;
      frees_ignored = 0;
      cycle_count = 0;
      quiet_tail = 1'b0;
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_ALLOC;
      req_size <= '0;
      req_free_offset <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      for (int p = 0; p < NumParts; p++) begin
         part_size[p]  = (p == 0) ? ResetSize0 : '0;
         part_count[p] = (p == 0) ? ResetCount0 : '0;
      end
      pool_rebuild();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_layout();
      test_partitions();
      test_backpressure();
      test_random(8, 110);
      test_full_rate();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d words: %0d allocated, %0d refused, %0d freed, %0d ignored",
               words_sent, allocs_ok, allocs_failed, frees_ok, frees_ignored);
      $display("over ten partition layouts incl. absent and saturated partitions");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
